// ----- rtl/core/aspf_pkg.sv -----
package aspf_pkg;

	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_MIN_GS = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MIN_AS = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_AS = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CRUISE = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_RATE = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_PMIN = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_PMAX = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_ROOT,
		ST_TGT,
		ST_FILT,
		ST_DIV,
		ST_MUL,
		ST_LIM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [14:0] min_gs;
		logic [14:0] min_as;
		logic [14:0] max_as;
		logic [14:0] cruise;
		logic [14:0] rate;
		logic [15:0] pmin;
		logic [15:0] pmax;
	} cfg_t;

endpackage

// ----- rtl/core/airspeed_pitch_feedforward.sv -----
// one item at a time: a new input item is accepted only in the idle state, once
// the previous item has reached its output register; two root passes (three
// squares, then 17 two-bit root steps), a divider of 30 steps and a
// shift-add multiplier make up the work for each item
// reset: config registers take their defaults, filter and last pitch clear
// an output item waits in its register while the next item is accepted
module airspeed_pitch_feedforward (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata, // vel_x vel_y vel_z wind_x wind_y wind_z demand_speed throttle
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata  // air_speed ground_speed target_speed speed_error pitch_adjust, pad
);
	import aspf_pkg::*;

	cfg_t   cfg_q;
	state_t st_q, st_d;
	logic [127:0] in_q;
	logic [1:0]  pass_q;
	logic [1:0]  k_q;
	logic [33:0] acc_q;
	logic [31:0] sq_q;
	logic [4:0]  cnt_q;
	logic [14:0] air_q, gnd_q;
	logic signed [15:0] tgt_q, ferr_q, last_q, pitch_q, quot_q, adj_q;
	logic [29:0] dvd_q;
	logic [15:0] dvs_q, rem_q;
	logic        neg_q, zero_q;
	logic [31:0] prod_q;
	logic        out_v_q;
	logic [79:0] out_q;
	logic        out_go;
	logic        sqs, sqd;
	logic [14:0] sqr;
	logic signed [15:0] comp;
	logic signed [16:0] rtrial;

	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == ST_IDLE);
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_q;
	assign out_go    = (st_q == ST_OUT) && (!out_v_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{15'd500, 15'd1000, 15'd3000, 15'd2000, 15'd35, 16'sd2859, -16'sd4289};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_GS: cfg_q.min_gs <= cfg_data[14:0];
				REG_MIN_AS: cfg_q.min_as <= cfg_data[14:0];
				REG_MAX_AS: cfg_q.max_as <= cfg_data[14:0];
				REG_CRUISE: cfg_q.cruise <= cfg_data[14:0];
				REG_RATE:   cfg_q.rate <= cfg_data[14:0];
				REG_PMIN:   cfg_q.pmin <= cfg_data;
				REG_PMAX:   cfg_q.pmax <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		logic signed [15:0] v, w;
		v = $signed(in_q[16*k_q +: 16]);
		w = $signed(in_q[48 + 16*k_q +: 16]);
		comp = (pass_q == 2'd0) ? v - w : v;
	end

	assign sqs = (st_q == ST_ACC) && (k_q == 2'd2);
	aspf_isqrt u_root (
		.clk(clk), .arst_n(arst_n), .start(sqs),
		.radicand(acc_q + {2'b00, sq_q}), .done(sqd), .root(sqr)
	);

	assign rtrial = {rem_q[14:0], dvd_q[29]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_v_q <= 1'b0;
			ferr_q <= '0;
			last_q <= '0;
		end else begin
			st_q <= st_d;
			out_v_q <= out_go || (out_v_q && !m_tready);
			if (st_q == ST_FILT)
				ferr_q <= (ferr_q >>> 1) + ($signed(tgt_q - {1'b0, air_q}) >>> 1);
			if (out_go)
				last_q <= adj_q;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (s_tvalid && s_tready) st_d = ST_SQ;
			ST_SQ:   st_d = ST_ACC;
			ST_ACC:  st_d = (k_q == 2'd2) ? ST_ROOT : ST_SQ;
			ST_ROOT: if (sqd) st_d = (pass_q == 2'd0) ? ST_SQ : ST_TGT;
			ST_TGT:  st_d = ST_FILT;
			ST_FILT: st_d = ST_DIV;
			ST_DIV:  if (cnt_q == 5'd30) st_d = ST_MUL;
			ST_MUL:  if (cnt_q == 5'd16) st_d = ST_LIM;
			ST_LIM:  st_d = ST_OUT;
			ST_OUT:  if (out_go) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		logic signed [15:0] t, d, r, p, a, l;
		logic signed [31:0] dm;
		unique case (st_q)
			ST_IDLE: begin
				in_q <= s_tdata; pass_q <= '0; k_q <= '0; acc_q <= '0;
			end
			ST_SQ: sq_q <= $unsigned(32'(comp) * 32'(comp));
			ST_ACC: begin
				acc_q <= acc_q + {2'b00, sq_q};
				k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
			end
			ST_ROOT: if (sqd) begin
				if (pass_q == 2'd0) air_q <= sqr; else gnd_q <= sqr;
				pass_q <= pass_q + 2'd1; acc_q <= '0;
			end
			ST_TGT: begin
				dm = $signed(in_q[111:96]) * 32'sd10;
				t = dm[15:0];
				if (gnd_q < cfg_q.min_gs) t = t + $signed({1'b0, cfg_q.min_gs} - {1'b0, gnd_q});
				if (t > $signed({1'b0, cfg_q.max_as})) t = {1'b0, cfg_q.max_as};
				if (t < $signed({1'b0, cfg_q.min_as})) t = {1'b0, cfg_q.min_as};
				tgt_q <= t;
			end
			ST_FILT: begin
				d = tgt_q - $signed({1'b0, cfg_q.cruise});
				if (d > 0) begin
					r = {1'b0, cfg_q.max_as} - {1'b0, cfg_q.cruise}; p = cfg_q.pmax;
				end else if (d < 0) begin
					r = {1'b0, cfg_q.cruise} - {1'b0, cfg_q.min_as}; p = cfg_q.pmin; d = -d;
				end else begin
					r = 16'sd1; p = '0;
				end
				pitch_q <= p; zero_q <= (r == 0);
				neg_q <= d[15] ^ r[15];
				dvs_q <= r[15] ? -r : r;
				dvd_q <= {(d[15] ? 16'(-d) : d), 14'd0};
				rem_q <= '0; quot_q <= '0; cnt_q <= '0;
			end
			ST_DIV: begin
				// numerator is |d|<<14: feed 14 zero bits after the 16 data bits
				if (cnt_q == 5'd30) begin
					quot_q <= zero_q ? '0 : (neg_q ? -quot_q : quot_q);
					cnt_q <= '0; prod_q <= '0;
				end else cnt_q <= cnt_q + 5'd1;
				if (cnt_q != 5'd30) begin
					dvd_q <= {dvd_q[28:0], 1'b0};
					if (!rtrial[16]) begin
						rem_q <= rtrial[15:0]; quot_q <= {quot_q[14:0], 1'b1};
					end else begin
						rem_q <= {rem_q[14:0], dvd_q[29]}; quot_q <= {quot_q[14:0], 1'b0};
					end
				end
			end
			ST_MUL: begin
				if (cnt_q == 5'd16) begin
					prod_q <= prod_q;
					adj_q <= prod_q[29:14];
				end else begin
					cnt_q <= cnt_q + 5'd1;
					if (pitch_q[cnt_q[3:0]])
						prod_q <= prod_q + (cnt_q == 5'd15 ?
							-(32'(quot_q) << 15) : (32'(quot_q) << cnt_q[3:0]));
				end
			end
			ST_LIM: begin
				a = ($signed(in_q[127:112]) >= 16'sd100) ? 16'sd0 : adj_q;
				if (a > last_q) begin
					l = last_q + $signed({1'b0, cfg_q.rate}); if (l < a) a = l;
				end else begin
					l = last_q - $signed({1'b0, cfg_q.rate}); if (l > a) a = l;
				end
				adj_q <= a;
			end
			ST_OUT: if (out_go) out_q <= {2'b00, 16'(adj_q), 16'(ferr_q), 16'(tgt_q), gnd_q, air_q};
			default: ;
		endcase
	end
endmodule

// ----- rtl/core/aspf_isqrt.sv -----
module aspf_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] radicand,
	output logic        done,
	output logic [14:0] root
);
	logic [33:0] rad_q;
	logic [17:0] rem_q;
	logic [16:0] res_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [19:0] rem_sh;
	logic [19:0] trial;
	logic        fits;

	assign rem_sh = {rem_q, rad_q[33:32]};
	assign trial  = rem_sh - {1'b0, res_q, 2'b01};
	assign fits   = rem_sh >= {1'b0, res_q, 2'b01};
	assign done   = busy_q && cnt_q == 5'd0;
	assign root   = (res_q > 17'd32767) ? 15'd32767 : res_q[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd17;
		end else if (busy_q && cnt_q != 5'd0) begin
			cnt_q <= cnt_q - 5'd1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q && cnt_q != 5'd0) begin
			rad_q <= {rad_q[31:0], 2'b00};
			rem_q <= fits ? trial[17:0] : rem_sh[17:0];
			res_q <= {res_q[15:0], fits};
		end
	end
endmodule

// ----- sim/tb_airspeed_pitch_feedforward.sv -----
module tb_airspeed_pitch_feedforward;
	timeunit 1ns;
	timeprecision 1ps;

	import aspf_pkg::*;

	typedef struct {
		logic signed [15:0] vel_x, vel_y, vel_z;
		logic signed [15:0] wind_x, wind_y, wind_z;
		logic signed [15:0] demand_speed, throttle;
	} tick_in_t;

	typedef struct packed {
		logic [15:0] pitch_adjust;
		logic [15:0] speed_error;
		logic [15:0] target_speed;
		logic [14:0] ground_speed;
		logic [14:0] air_speed;
	} tick_out_t;

	typedef struct {
		tick_in_t in;
		bit has_known;
		tick_out_t known;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;

	airspeed_pitch_feedforward dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// predictor copy of registers and state
	int p_min_gs, p_min_as, p_max_as, p_cruise, p_rate, p_pmin, p_pmax;
	int p_filt, p_last;

	tick_out_t pending_ticks[$];
	int errors = 0;
	bit no_idle = 0;
	bit hold_req = 0;
	row_t rows[$];

	function automatic int wrap16(longint v);
		logic signed [15:0] s;
		s = v[15:0];
		return s;
	endfunction

	function automatic int root_sat(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return (res > 32767) ? 32767 : int'(res);
	endfunction

	function automatic longint unsigned sqr(int c);
		longint p;
		p = longint'(c) * c;
		return p;
	endfunction

	function automatic tick_out_t predict_tick(tick_in_t t);
		int air, ground, target, delta, range_v, pitch, quot, adj, lim, diff_err;
		logic [31:0] prod;
		tick_out_t o;
		air = root_sat(sqr(wrap16(t.vel_x - t.wind_x)) + sqr(wrap16(t.vel_y - t.wind_y))
			+ sqr(wrap16(t.vel_z - t.wind_z)));
		ground = root_sat(sqr(t.vel_x) + sqr(t.vel_y) + sqr(t.vel_z));
		target = wrap16(longint'(t.demand_speed) * 10);
		if (ground < p_min_gs) target = wrap16(target + (p_min_gs - ground));
		if (target > p_max_as) target = p_max_as;
		if (target < p_min_as) target = p_min_as;
		diff_err = wrap16(target - air);
		p_filt = wrap16((p_filt >>> 1) + (diff_err >>> 1));
		delta = wrap16(target - p_cruise);
		if (delta > 0) begin
			range_v = wrap16(p_max_as - p_cruise);
			pitch = p_pmax;
		end else if (delta < 0) begin
			range_v = wrap16(p_cruise - p_min_as);
			pitch = p_pmin;
			delta = wrap16(-longint'(delta));
		end else begin
			range_v = 1;
			pitch = 0;
		end
		if (range_v == 0) quot = 0;
		else quot = wrap16((longint'(delta) * 16384) / range_v);
		prod = 32'(longint'(quot) * pitch);
		prod = prod << 2;
		adj = wrap16(prod[31:16]);
		if (t.throttle >= 100) adj = 0;
		if (adj > p_last) begin
			lim = wrap16(p_last + p_rate);
			if (lim < adj) adj = lim;
		end else begin
			lim = wrap16(p_last - p_rate);
			if (lim > adj) adj = lim;
		end
		p_last = adj;
		o.air_speed = air[14:0];
		o.ground_speed = ground[14:0];
		o.target_speed = target[15:0];
		o.speed_error = p_filt[15:0];
		o.pitch_adjust = adj[15:0];
		return o;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MIN_GS: p_min_gs = int'(val[14:0]);
			REG_MIN_AS: p_min_as = int'(val[14:0]);
			REG_MAX_AS: p_max_as = int'(val[14:0]);
			REG_CRUISE: p_cruise = int'(val[14:0]);
			REG_RATE: p_rate = int'(val[14:0]);
			REG_PMIN: p_pmin = wrap16(val);
			REG_PMAX: p_pmax = wrap16(val);
			default: ;
		endcase
	endtask

	task automatic write_all(logic [15:0] gs, logic [15:0] mn, logic [15:0] mx,
			logic [15:0] cr, logic [15:0] rt, logic [15:0] pn, logic [15:0] px);
		write_reg(REG_MIN_GS, gs);
		write_reg(REG_MIN_AS, mn);
		write_reg(REG_MAX_AS, mx);
		write_reg(REG_CRUISE, cr);
		write_reg(REG_RATE, rt);
		write_reg(REG_PMIN, pn);
		write_reg(REG_PMAX, px);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_tick(tick_in_t t, bit has_known, tick_out_t known);
		tick_out_t o;
		if (!no_idle && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {t.throttle, t.demand_speed, t.wind_z, t.wind_y, t.wind_x,
			t.vel_z, t.vel_y, t.vel_x};
		do @(posedge clk); while (!s_tready);
		o = predict_tick(t);
		if (has_known && o != known) begin
			$display("%0t predictor row mismatch exp %h act %h", $time, known, o);
			errors++;
		end
		pending_ticks.push_back(has_known ? known : o);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_ticks.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd16;
		return 16'($urandom);
	endfunction

	function automatic tick_in_t random_tick;
		tick_in_t t;
		if ($urandom_range(99) < 80) begin
			t.vel_x = 16'($urandom_range(8000) - 4000);
			t.vel_y = 16'($urandom_range(8000) - 4000);
			t.vel_z = 16'($urandom_range(1000) - 500);
			t.wind_x = 16'($urandom_range(3000) - 1500);
			t.wind_y = 16'($urandom_range(3000) - 1500);
			t.wind_z = 16'($urandom_range(200) - 100);
			t.demand_speed = 16'($urandom_range(450));
			t.throttle = 16'($urandom_range(200) - 50);
		end else begin
			t.vel_x = rnd16(); t.vel_y = rnd16(); t.vel_z = rnd16();
			t.wind_x = rnd16(); t.wind_y = rnd16(); t.wind_z = rnd16();
			t.demand_speed = rnd16(); t.throttle = rnd16();
		end
		return t;
	endfunction

	function automatic row_t mk(int vx, int vy, int vz, int wx, int wy, int wz, int dm, int th);
		row_t r;
		r.in.vel_x = 16'(vx); r.in.vel_y = 16'(vy); r.in.vel_z = 16'(vz);
		r.in.wind_x = 16'(wx); r.in.wind_y = 16'(wy); r.in.wind_z = 16'(wz);
		r.in.demand_speed = 16'(dm); r.in.throttle = 16'(th);
		r.has_known = 0;
		r.known = '0;
		return r;
	endfunction

	task automatic random_phase(int n);
		tick_out_t none;
		none = '0;
		repeat (n) send_tick(random_tick(), 0, none);
		drain();
	endtask

	// result side
	initial begin
		int hold;
		tick_out_t got, want;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata[77:0];
				if (pending_ticks.size() == 0) begin
					$display("%0t unexpected item %h", $time, got);
					errors++;
				end else begin
					want = pending_ticks.pop_front();
					if (got.air_speed !== want.air_speed) begin
						$display("%0t air_speed exp %0d act %0d", $time,
							want.air_speed, got.air_speed);
						errors++;
					end
					if (got.ground_speed !== want.ground_speed) begin
						$display("%0t ground_speed exp %0d act %0d", $time,
							want.ground_speed, got.ground_speed);
						errors++;
					end
					if (got.target_speed !== want.target_speed) begin
						$display("%0t target_speed exp %0d act %0d", $time,
							$signed(want.target_speed), $signed(got.target_speed));
						errors++;
					end
					if (got.speed_error !== want.speed_error) begin
						$display("%0t speed_error exp %0d act %0d", $time,
							$signed(want.speed_error), $signed(got.speed_error));
						errors++;
					end
					if (got.pitch_adjust !== want.pitch_adjust) begin
						$display("%0t pitch_adjust exp %0d act %0d", $time,
							$signed(want.pitch_adjust), $signed(got.pitch_adjust));
						errors++;
					end
				end
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 0;
				hold = 600;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 26);
			end
		end
	end

	initial begin
		#4ms;
		$display("tb_airspeed_pitch_feedforward: errors");
		$finish;
	end

	initial begin
		tick_out_t first;
		p_min_gs = 500; p_min_as = 1000; p_max_as = 3000; p_cruise = 2000;
		p_rate = 35; p_pmin = 2859; p_pmax = -4289;
		p_filt = 0; p_last = 0;

		rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
		first.air_speed = 0; first.ground_speed = 0; first.target_speed = 1000;
		first.speed_error = 500; first.pitch_adjust = 35;
		rows[0].has_known = 1;
		rows[0].known = first;
		rows.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768, 0, 0));
		rows.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767, 300, 0));
		rows.push_back(mk(0, 0, 0, 32767, 32767, 32767, 32767, 32767));
		rows.push_back(mk(1000, 0, 0, 0, 0, 0, -32768, 100));
		rows.push_back(mk(1000, 0, 0, 0, 0, 0, 200, 99));
		rows.push_back(mk(1500, 800, -20, 300, -200, 0, 300, 0));
		rows.push_back(mk(1500, 800, -20, 300, -200, 0, 150, -32768));
		rows.push_back(mk(100, 0, 0, 0, 0, 0, 100, 0));
		rows.push_back(mk(-32768, 0, 0, -32768, 0, 0, 50, 10));
		rows.push_back(mk(0, 32767, 0, 0, 0, -32768, 3000, 100));
		rows.push_back(mk(-4000, 3000, 0, 0, 0, 0, 3276, 50));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_tick(rows[i].in, rows[i].has_known, rows[i].known);
		drain();
		random_phase(250);

		// zero ranges and zero rate
		write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);
		random_phase(120);

		// all limits at top
		write_all(16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
		random_phase(120);

		// crossed limits, receiver held off to fill the pipe
		write_all(16'd1200, 16'd3500, 16'd1500, 16'd2500, 16'd500, 16'h8000, 16'h8000);
		hold_req = 1;
		random_phase(200);

		// no idling on either side
		write_all(16'd500, 16'd1000, 16'd3000, 16'd2000, 16'd35, 16'd2859, 16'hef3f);
		no_idle = 1;
		random_phase(300);
		no_idle = 0;

		repeat (4) begin
			write_all(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
			random_phase(80);
			write_all(16'($urandom_range(1000)), 16'($urandom_range(500, 1500)),
				16'($urandom_range(2500, 4000)), 16'($urandom_range(1500, 2500)),
				16'($urandom_range(200)), rnd16(), rnd16());
			random_phase(90);
		end

		repeat (200) @(posedge clk);
		if (errors == 0 && pending_ticks.size() == 0)
			$display("tb_airspeed_pitch_feedforward: clean");
		else
			$display("tb_airspeed_pitch_feedforward: errors");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/aspf_pkg.sv
rtl/core/aspf_isqrt.sv
rtl/core/airspeed_pitch_feedforward.sv
sim/tb_airspeed_pitch_feedforward.sv
